// File: rtl/tsq_pkg.sv
// Package for the two-stack queue checker.
// Holds sizes, command codes, item structs and the controller state type.
// No dependencies.
package tsq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic                        command;
    logic signed [WORD_BITS-1:0] data_value;
  } tsq_in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] popped_word;
    logic                        was_empty;
    logic                        check_passed;
    logic                        all_passed;
    logic                        overflow;
  } tsq_out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_POP_READ
  } tsq_state_t;

endpackage

// File: rtl/tsq_stream_if.sv
// Valid/ready channel interfaces for the two-stack queue checker.
// Depends on tsq_pkg for the item structs.
interface tsq_in_if;
  logic                  valid;
  logic                  ready;
  tsq_pkg::tsq_in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tsq_out_if;
  logic                   valid;
  logic                   ready;
  tsq_pkg::tsq_out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/two_stack_queue_checker_core.sv
// Two-stack queue checker: FIFO built from a push stack and a pop stack in RAM.
// Depends on tsq_pkg and the channel interfaces in tsq_stream_if.sv.
//
//   channel    dir  handshake     item
//   request    in   valid/ready   command, data_value
//   response   out  valid/ready   popped_word, was_empty, check_passed,
//                                 all_passed, overflow
//
// Push, empty pop: result registered in the cycle after accept.
// Pop with words on the pop stack: one RAM read, then the result register.
// Pop with an empty pop stack: the read-then-write move loop first copies the whole
// push stack through the two stack RAMs (one word a cycle), then the pop read.
// One item in flight; request.ready waits for a free result register.
// Synchronous reset clears counts, state and the sticky flag; RAMs are not cleared.
module two_stack_queue_checker_core (
  input  logic      clk,
  input  logic      rst,
  tsq_in_if.sink    request,
  tsq_out_if.source response
);
  import tsq_pkg::*;

  logic [WORD_BITS-1:0] push_mem [QUEUE_DEPTH];
  logic [WORD_BITS-1:0] pop_mem  [QUEUE_DEPTH];

  tsq_state_t           state, state_next;
  logic [COUNT_BITS-1:0] push_count, push_count_next;
  logic [COUNT_BITS-1:0] pop_count, pop_count_next;
  logic                  move_pend, move_pend_next;
  logic [WORD_BITS-1:0]  expected, expected_next;
  logic                  all_ok, all_ok_next;
  logic                  res_valid;
  tsq_out_item_t         res, res_next;
  logic                  res_load;

  logic                  push_we, push_re, pop_we, pop_re;
  logic [ADDR_BITS-1:0]  push_waddr, push_raddr, pop_waddr, pop_raddr;
  logic [WORD_BITS-1:0]  push_rdata, pop_rdata;

  logic [COUNT_BITS-1:0] push_dec, pop_dec;
  logic [COUNT_BITS:0]   fill;
  logic                  full, accept;

  assign push_dec   = push_count - COUNT_BITS'(1);
  assign pop_dec    = pop_count - COUNT_BITS'(1);
  assign fill       = {1'b0, push_count} + {1'b0, pop_count};
  assign full       = fill >= (COUNT_BITS + 1)'(QUEUE_DEPTH);
  assign push_waddr = push_count[ADDR_BITS-1:0];
  assign push_raddr = push_dec[ADDR_BITS-1:0];
  assign pop_waddr  = pop_count[ADDR_BITS-1:0];
  assign pop_raddr  = pop_dec[ADDR_BITS-1:0];

  assign request.ready  = (state == ST_IDLE) && (!res_valid || response.ready);
  assign accept         = request.valid && request.ready;
  assign response.valid = res_valid;
  assign response.item  = res;

  always_ff @(posedge clk) begin
    if (push_we) begin
      push_mem[push_waddr] <= request.item.data_value;
    end
    if (push_re) begin
      push_rdata <= push_mem[push_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_we) begin
      pop_mem[pop_waddr] <= push_rdata;
    end
    if (pop_re) begin
      pop_rdata <= pop_mem[pop_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      push_count <= '0;
      pop_count  <= '0;
      move_pend  <= 1'b0;
      all_ok     <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      push_count <= push_count_next;
      pop_count  <= pop_count_next;
      move_pend  <= move_pend_next;
      all_ok     <= all_ok_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (response.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    expected <= expected_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  always_comb begin
    state_next      = state;
    push_count_next = push_count;
    pop_count_next  = pop_count;
    move_pend_next  = 1'b0;
    expected_next   = expected;
    push_we         = 1'b0;
    push_re         = 1'b0;
    pop_we          = 1'b0;
    pop_re          = 1'b0;
    res_load        = 1'b0;
    res_next        = '{popped_word: '0, was_empty: 1'b0, check_passed: 1'b1,
                        all_passed: 1'b0, overflow: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.item.command == CMD_PUSH) begin
            res_load = 1'b1;
            if (full) begin
              res_next.overflow = 1'b1;
            end else begin
              push_we         = 1'b1;
              push_count_next = push_count + COUNT_BITS'(1);
            end
          end else begin
            expected_next = request.item.data_value;
            if (push_count == '0 && pop_count == '0) begin
              res_load              = 1'b1;
              res_next.was_empty    = 1'b1;
              res_next.check_passed = &request.item.data_value;
            end else if (pop_count != '0) begin
              pop_re         = 1'b1;
              pop_count_next = pop_dec;
              state_next     = ST_POP_READ;
            end else begin
              state_next = ST_MOVE;
            end
          end
        end
      end
      ST_MOVE: begin
        // read push top, write it to pop stack the next cycle
        if (move_pend) begin
          pop_we         = 1'b1;
          pop_count_next = pop_count + COUNT_BITS'(1);
        end
        if (push_count != '0) begin
          push_re         = 1'b1;
          push_count_next = push_dec;
          move_pend_next  = 1'b1;
        end else if (!move_pend) begin
          pop_re         = 1'b1;
          pop_count_next = pop_dec;
          state_next     = ST_POP_READ;
        end
      end
      ST_POP_READ: begin
        res_load              = 1'b1;
        res_next.popped_word  = pop_rdata;
        res_next.check_passed = (pop_rdata == expected);
        state_next            = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_next.all_passed = all_ok & res_next.check_passed;
    all_ok_next         = res_load ? res_next.all_passed : all_ok;
  end

endmodule

// File: tb/sv/tb.sv
// Testbench for two_stack_queue_checker_core: push/pop traffic with random idling and stalls.
// A two-stack model class predicts every result item and compares it.
// Depends on tsq_pkg, tsq_stream_if.sv and the core RTL.
module tb;
  import tsq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_ITEMS   = 250;
  localparam int TAIL_ITEMS     = 150;

  class two_stack_model;
    logic [WORD_BITS-1:0] push_mem [QUEUE_DEPTH];
    logic [WORD_BITS-1:0] pop_mem  [QUEUE_DEPTH];
    int unsigned          push_cnt;
    int unsigned          pop_cnt;
    bit                   all_ok;
    tsq_out_item_t        pending_results [$];
    int unsigned          errors;

    function new();
      push_cnt = 0;
      pop_cnt  = 0;
      all_ok   = 1'b1;
      errors   = 0;
    endfunction

    function int unsigned occupancy();
      return push_cnt + pop_cnt;
    endfunction

    function logic [WORD_BITS-1:0] front();
      if (pop_cnt != 0) return pop_mem[pop_cnt-1];
      return push_mem[0];
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void take_request(tsq_in_item_t it);
      tsq_out_item_t r;
      r = '0;
      r.check_passed = 1'b1;
      if (it.command == CMD_PUSH) begin
        if (push_cnt + pop_cnt >= QUEUE_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          push_mem[push_cnt] = it.data_value;
          push_cnt++;
        end
      end else if (push_cnt == 0 && pop_cnt == 0) begin
        r.was_empty    = 1'b1;
        r.check_passed = (it.data_value == '1);
      end else begin
        if (pop_cnt == 0) begin
          while (push_cnt > 0 && pop_cnt < QUEUE_DEPTH) begin
            push_cnt--;
            pop_mem[pop_cnt] = push_mem[push_cnt];
            pop_cnt++;
          end
        end
        pop_cnt--;
        r.popped_word  = pop_mem[pop_cnt];
        r.check_passed = (r.popped_word == it.data_value);
      end
      all_ok       = all_ok & r.check_passed;
      r.all_passed = all_ok;
      pending_results = {pending_results, r};
    endfunction

    function void compare_result(tsq_out_item_t got);
      tsq_out_item_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %h", got);
        errors++;
        return;
      end
      exp = pending_results[0];
      pending_results.delete(0);
      if (got.popped_word !== exp.popped_word) begin
        $error("popped_word: expected %h, actual %h", exp.popped_word, got.popped_word);
        errors++;
      end
      if (got.was_empty !== exp.was_empty) begin
        $error("was_empty: expected %b, actual %b", exp.was_empty, got.was_empty);
        errors++;
      end
      if (got.check_passed !== exp.check_passed) begin
        $error("check_passed: expected %b, actual %b", exp.check_passed, got.check_passed);
        errors++;
      end
      if (got.all_passed !== exp.all_passed) begin
        $error("all_passed: expected %b, actual %b", exp.all_passed, got.all_passed);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %b, actual %b", exp.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tsq_in_if  req_ch ();
  tsq_out_if rsp_ch ();

  two_stack_model model = new();

  bit          idle_on;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_cnt     = 0;
  int unsigned gap_cnt      = 0;
  int unsigned stall_cycles = 0;
  int unsigned sent_items;

  two_stack_queue_checker_core DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: checks result items, stalls in short bursts or one long hold
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) model.compare_result(rsp_ch.item);
      if (hold_cnt != 0) begin
        hold_cnt     <= hold_cnt - 1;
        rsp_ch.ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
        hold_seen    <= hold_reqs;
        hold_cnt     <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (gap_cnt != 0) begin
        gap_cnt      <= gap_cnt - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_cnt      <= $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("two_stack_queue_checker_core regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [WORD_BITS-1:0] any_word();
    case ($urandom_range(0, 11))
      0:       return {1'b1, {(WORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(WORD_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [WORD_BITS-1:0] word);
    tsq_in_item_t it;
    int unsigned  n;
    it.command    = cmd;
    it.data_value = word;
    req_ch.item  <= it;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model.take_request(it);
    sent_items++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (model.outstanding() != 0);
  endtask

  task automatic random_op(input int push_pct, input int bad_pct);
    logic [WORD_BITS-1:0] w;
    if ($urandom_range(0, 99) < push_pct) begin
      send_item(CMD_PUSH, any_word());
    end else begin
      if (model.occupancy() == 0) begin
        w = ($urandom_range(0, 3) != 0) ? '1 : any_word();
      end else begin
        w = model.front();
        if ($urandom_range(0, 99) < bad_pct) w ^= WORD_BITS'(1) << $urandom_range(0, WORD_BITS-1);
      end
      send_item(CMD_POP, w);
    end
  endtask

  initial begin
    int unsigned phase_idx;
    int unsigned len;
    int          push_pct;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.item  <= '0;
    idle_on      = 1'b1;
    sent_items   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pops, extreme words, moves with both stacks in use, failed checks
    send_item(CMD_POP,  32'hFFFF_FFFF);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 32'h0000_0000);
    send_item(CMD_PUSH, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 32'h0000_0001);
    send_item(CMD_POP,  32'h8000_0000);
    send_item(CMD_POP,  32'h7FFF_FFFF);
    send_item(CMD_PUSH, 32'h5555_5555);
    send_item(CMD_PUSH, 32'hAAAA_AAAA);
    send_item(CMD_POP,  32'h0000_0000);
    send_item(CMD_POP,  32'hFFFF_FFFF);
    send_item(CMD_POP,  32'h0000_0001);
    send_item(CMD_POP,  32'h5555_5555);
    send_item(CMD_POP,  32'hAAAA_AAAA);
    send_item(CMD_POP,  32'hFFFF_FFFF);
    send_item(CMD_PUSH, 32'h1234_5678);
    send_item(CMD_POP,  32'h1234_5679);
    send_item(CMD_POP,  32'h0000_0000);
    send_item(CMD_PUSH, 32'h0000_0007);
    send_item(CMD_POP,  32'h0000_0007);
    wait_drained();

    phase_idx = 0;
    while (sent_items < RANDOM_ITEMS) begin
      len = $urandom_range(8, 50);
      case ($urandom_range(0, 2))
        0:       push_pct = 35;
        1:       push_pct = 50;
        default: push_pct = 70;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase_idx == 3) begin
        idle_on = 1'b0;
        hold_reqs++;
      end
      repeat (len) random_op(push_pct, 10);
      wait_drained();
      phase_idx++;
    end

    // fill to capacity, overflow, then refill the freed slot
    idle_on = 1'b1;
    while (model.occupancy() < QUEUE_DEPTH) random_op(95, 5);
    repeat (3) send_item(CMD_PUSH, any_word());
    send_item(CMD_POP, model.front());
    send_item(CMD_PUSH, any_word());
    send_item(CMD_PUSH, any_word());
    wait_drained();

    // final traffic with no idling on either side
    idle_on = 1'b0;
    repeat (TAIL_ITEMS) random_op(20, 5);
    repeat (3) random_op(0, 0);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.outstanding() == 0)
      $display("two_stack_queue_checker_core regression: pass");
    else
      $display("two_stack_queue_checker_core regression: fail");
    $finish;
  end

endmodule
